/* hdl/gos_pkg.sv */
// Shared types, constants and helper functions for the point snap core.
// No dependencies; imported by gos_rem, gos_cell and the top level.
package gos_pkg;

    localparam int C_MAX_RECTS  = 64;
    localparam int C_COORD_BITS = 32;
    localparam int C_GRID_BITS  = 24;
    localparam int C_BEST_BITS  = C_GRID_BITS + 3;
    localparam int C_DIV_BITS   = 32;
    localparam int C_DCNT_BITS  = $clog2(C_DIV_BITS + 1);

    localparam logic signed [63:0] C_CMAX = (64'sd1 <<< (C_COORD_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] C_CMIN = -C_CMAX - 64'sd1;

    localparam logic [1:0] C_MODE_APPEND = 2'd0;
    localparam logic [1:0] C_MODE_QUERY  = 2'd1;
    localparam logic [1:0] C_MODE_CLEAR  = 2'd2;

    localparam logic C_REG_GRID = 1'b0;
    localparam logic C_REG_SNAP = 1'b1;

    localparam logic C_SNAP_GRID   = 1'b0;
    localparam logic C_SNAP_OBJECT = 1'b1;

    localparam logic [2:0] C_CAND_LEFT   = 3'd0;
    localparam logic [2:0] C_CAND_RIGHT  = 3'd1;
    localparam logic [2:0] C_CAND_BOTTOM = 3'd2;
    localparam logic [2:0] C_CAND_TOP    = 3'd3;
    localparam logic [2:0] C_CAND_CENTER = 3'd4;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] rect_left;
        logic signed [31:0] rect_right;
        logic signed [31:0] rect_bottom;
        logic signed [31:0] rect_top;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] snapped_x;
        logic signed [31:0] snapped_y;
        logic               object_hit;
        logic               table_full;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic signed [31:0] bottom;
        logic signed [31:0] top;
    } t_rect;

    typedef struct packed {
        logic                   valid;
        logic [C_BEST_BITS-1:0] best;
        logic signed [31:0]     rx;
        logic signed [31:0]     ry;
        logic                   hit;
    } t_tok;

    function automatic logic [31:0] f_absdiff(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
        logic signed [32:0] d;
        logic [32:0]        n;
        d = {a[31], a} - {b[31], b};
        n = -d;
        return d[32] ? n[31:0] : d[31:0];
    endfunction

    // truncating half of a sum
    function automatic logic signed [31:0] f_half_sum(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        s = s + {32'd0, s[32]};
        return s[32:1];
    endfunction

    // floor remainder from the remainder of the magnitude
    function automatic logic [C_GRID_BITS-1:0] f_floor_rem(input logic signed [32:0] t,
                                                         input logic [C_GRID_BITS-1:0] rt,
                                                         input logic [C_GRID_BITS-1:0] s);
        return (t[32] && (rt != '0)) ? (s - rt) : rt;
    endfunction

    function automatic logic [31:0] f_sat(input logic signed [33:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > C_CMAX) begin
            w = C_CMAX;
        end else if (w < C_CMIN) begin
            w = C_CMIN;
        end
        return w[31:0];
    endfunction

endpackage

/* hdl/grid_or_object_point_snap_core.sv */
// Point snap core. Items append a rectangle, clear the table or ask a query,
// which gives one result item. The time of a grid query is set by the 32-step
// remainder units that divide both coordinates by the grid pitch in parallel;
// that of an object query by the length of the cell chain that the running
// best travels through, one cell per cycle. One item is in work at a time; a
// result waiting at the output does not hold up further appends or clears once
// it is registered.
// Depends on gos_pkg, gos_rem and gos_cell.
module grid_or_object_point_snap_core #(
    parameter  int MAX_RECTS = gos_pkg::C_MAX_RECTS,
    localparam int CW        = $clog2(MAX_RECTS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gos_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gos_pkg::t_out_item  o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import gos_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_GSTART = 3'd1;
    localparam logic [2:0] S_GWAIT  = 3'd2;
    localparam logic [2:0] S_GFIN   = 3'd3;
    localparam logic [2:0] S_OPRE   = 3'd4;
    localparam logic [2:0] S_OSCAN  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    localparam logic [1:0] C_PRE_WAIT = 2'd3;

    logic [2:0]             r_state, n_state;
    logic [C_GRID_BITS-1:0] r_grid;
    logic                   r_snap;
    logic [CW-1:0]          r_count;
    logic                   r_overflow;
    logic [1:0]             r_wait;
    logic [C_GRID_BITS-1:0] r_s;
    logic signed [31:0]     r_px, r_py;
    logic signed [32:0]     r_tx, r_ty;
    logic [C_GRID_BITS-1:0] r_rfx, r_rfy;
    t_out_item              r_res;
    t_out_item              r_out;
    logic                   r_out_valid;

    logic                   w_acc;
    logic                   w_full;
    logic                   w_wr_en;
    logic                   w_cfg_wr;
    logic [C_GRID_BITS-1:0] w_s_eff;
    logic [C_GRID_BITS-1:0] w_half;
    logic                   w_start;
    logic [31:0]            w_absx, w_absy;
    logic [32:0]            w_negx, w_negy;
    logic                   w_done_x, w_done_y;
    logic [C_GRID_BITS-1:0] w_remx, w_remy;
    logic signed [33:0]     w_gx, w_gy;
    logic                   w_out_free;
    t_rect                  w_rect;
    t_tok                   w_tok [MAX_RECTS+1];
    logic [CW-1:0]          w_crem [MAX_RECTS+1];

    assign w_acc      = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CW'(MAX_RECTS));
    assign w_wr_en    = w_acc && (i_in_item.mode == C_MODE_APPEND) && !w_full;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_s_eff    = (r_grid == '0) ? C_GRID_BITS'(1) : r_grid;
    assign w_half     = {1'b0, w_s_eff[C_GRID_BITS-1:1]};
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_rect.left   = i_in_item.rect_left;
    assign w_rect.right  = i_in_item.rect_right;
    assign w_rect.bottom = i_in_item.rect_bottom;
    assign w_rect.top    = i_in_item.rect_top;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= C_GRID_BITS'(1);
            r_snap <= C_SNAP_GRID;
        end else if (w_cfg_wr) begin
            if (paddr[2] == C_REG_GRID) begin
                r_grid <= pwdata[C_GRID_BITS-1:0];
            end else begin
                r_snap <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == C_REG_SNAP) ? {31'd0, r_snap}
                                             : {{(32 - C_GRID_BITS){1'b0}}, r_grid};
    assign pready = 1'b1;

    // grid path
    assign w_start = (r_state == S_GSTART);
    assign w_negx  = -r_tx;
    assign w_negy  = -r_ty;
    assign w_absx  = r_tx[32] ? w_negx[31:0] : r_tx[31:0];
    assign w_absy  = r_ty[32] ? w_negy[31:0] : r_ty[31:0];
    assign w_gx    = {r_tx[32], r_tx} - {{(34 - C_GRID_BITS){1'b0}}, r_rfx};
    assign w_gy    = {r_ty[32], r_ty} - {{(34 - C_GRID_BITS){1'b0}}, r_rfy};

    gos_rem u_rem_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_absx),
        .i_divisor  (r_s),
        .o_done     (w_done_x),
        .o_rem      (w_remx)
    );

    gos_rem u_rem_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_absy),
        .i_divisor  (r_s),
        .o_done     (w_done_y),
        .o_rem      (w_remy)
    );

    // object path: token enters the first cell
    assign w_tok[0]  = {(r_state == S_OPRE) && (r_wait == 2'd0),
                        {3'b000, r_s} + {1'b0, r_s, 2'b00},
                        r_px, r_py, 1'b0};
    assign w_crem[0] = r_count;

    for (genvar g = 0; g < MAX_RECTS; g++) begin : g_cell
        gos_cell #(
            .MAX_RECTS (MAX_RECTS),
            .IDX       (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr_en  (w_wr_en),
            .i_wr_idx (r_count),
            .i_rect   (w_rect),
            .i_px     (r_px),
            .i_py     (r_py),
            .i_tok    (w_tok[g]),
            .i_rem    (w_crem[g]),
            .o_tok    (w_tok[g+1]),
            .o_rem    (w_crem[g+1])
        );
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && (i_in_item.mode == C_MODE_QUERY)) begin
                    n_state = (r_snap == C_SNAP_OBJECT) ? S_OPRE : S_GSTART;
                end
            end
            S_GSTART: n_state = S_GWAIT;
            S_GWAIT: begin
                if (w_done_x && w_done_y) begin
                    n_state = S_GFIN;
                end
            end
            S_GFIN: n_state = S_DONE;
            S_OPRE: begin
                if (r_wait == 2'd0) begin
                    n_state = S_OSCAN;
                end
            end
            S_OSCAN: begin
                if (w_tok[MAX_RECTS].valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_wait      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                case (i_in_item.mode)
                    C_MODE_APPEND: begin
                        if (w_full) begin
                            r_overflow <= 1'b1;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    C_MODE_CLEAR: begin
                        r_count    <= '0;
                        r_overflow <= 1'b0;
                    end
                    C_MODE_QUERY: r_wait <= C_PRE_WAIT;
                    default: ;
                endcase
            end else if ((r_state == S_OPRE) && (r_wait != 2'd0)) begin
                r_wait <= r_wait - 2'd1;
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_in_item.mode == C_MODE_QUERY)) begin
            r_px <= i_in_item.point_x;
            r_py <= i_in_item.point_y;
            r_s  <= w_s_eff;
            r_tx <= {i_in_item.point_x[31], i_in_item.point_x} + {9'd0, w_half};
            r_ty <= {i_in_item.point_y[31], i_in_item.point_y} + {9'd0, w_half};
        end
        if ((r_state == S_GWAIT) && w_done_x) begin
            r_rfx <= f_floor_rem(r_tx, w_remx, r_s);
            r_rfy <= f_floor_rem(r_ty, w_remy, r_s);
        end
        if (r_state == S_GFIN) begin
            r_res.snapped_x  <= f_sat(w_gx);
            r_res.snapped_y  <= f_sat(w_gy);
            r_res.object_hit <= 1'b0;
            r_res.table_full <= r_overflow;
        end else if ((r_state == S_OSCAN) && w_tok[MAX_RECTS].valid) begin
            r_res.snapped_x  <= w_tok[MAX_RECTS].rx;
            r_res.snapped_y  <= w_tok[MAX_RECTS].ry;
            r_res.object_hit <= w_tok[MAX_RECTS].hit;
            r_res.table_full <= r_overflow;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[MAX_RECTS].valid |-> (r_state == S_OSCAN))
        else $error("scan token left the chain outside a scan");

    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done_x || w_done_y) |-> ((r_state == S_GWAIT) && w_done_x && w_done_y))
        else $error("remainder units out of step with the sequencer");

    a_full_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in_item.mode == C_MODE_APPEND) && w_full) |=> r_overflow)
        else $error("append to a full table did not set the overflow flag");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (r_count != '0) && (r_count <= CW'(MAX_RECTS)))
        else $error("rectangle count out of range after append");

endmodule

/* hdl/gos_rem.sv */
// Restoring remainder unit, one quotient bit per cycle.
// Depends on gos_pkg.
module gos_rem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [gos_pkg::C_DIV_BITS-1:0]  i_dividend,
    input  logic [gos_pkg::C_GRID_BITS-1:0] i_divisor,
    output logic                           o_done,
    output logic [gos_pkg::C_GRID_BITS-1:0] o_rem
);
    import gos_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [C_DCNT_BITS-1:0] r_cnt;
    logic [C_DIV_BITS-1:0]  r_dvd;
    logic [C_GRID_BITS-1:0] r_rem;

    logic [C_GRID_BITS:0]   w_shift;
    logic [C_GRID_BITS:0]   w_diff;
    logic [C_GRID_BITS-1:0] n_rem;

    always_comb begin
        w_shift = {r_rem, r_dvd[C_DIV_BITS-1]};
        w_diff  = w_shift - {1'b0, i_divisor};
        n_rem   = (w_shift >= {1'b0, i_divisor}) ? w_diff[C_GRID_BITS-1:0]
                                                 : w_shift[C_GRID_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_DCNT_BITS'(C_DIV_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - C_DCNT_BITS'(1);
                if (r_cnt == C_DCNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* hdl/gos_cell.sv */
// One rectangle cell of the scan chain: holds an entry, ranks its five
// candidates against the broadcast point and passes the running best on.
// Depends on gos_pkg.
module gos_cell #(
    parameter  int MAX_RECTS = gos_pkg::C_MAX_RECTS,
    parameter  int IDX       = 0,
    localparam int CW        = $clog2(MAX_RECTS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [CW-1:0]      i_wr_idx,
    input  gos_pkg::t_rect     i_rect,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  gos_pkg::t_tok      i_tok,
    input  logic [CW-1:0]      i_rem,
    output gos_pkg::t_tok      o_tok,
    output logic [CW-1:0]      o_rem
);
    import gos_pkg::*;

    t_rect              r_rect;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_cy;

    logic [31:0] r_a0, r_a1, r_a2, r_a3, r_ax, r_ay;
    logic [32:0] r_d4;
    logic [31:0] r_m01, r_m23;
    logic [2:0]  r_i01, r_i23;
    logic [32:0] r_dmin;
    logic [2:0]  r_sel;

    t_tok          r_tok;
    logic [CW-1:0] r_rem;

    logic [31:0] w_ma;
    logic [2:0]  w_ia;
    t_tok        n_tok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == CW'(IDX))) begin
            r_rect <= i_rect;
            r_cx   <= f_half_sum(i_rect.left, i_rect.right);
            r_cy   <= f_half_sum(i_rect.bottom, i_rect.top);
        end
    end

    // candidate distances, three stages
    always_comb begin
        if (r_m23 < r_m01) begin
            w_ma = r_m23;
            w_ia = r_i23;
        end else begin
            w_ma = r_m01;
            w_ia = r_i01;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a0  <= f_absdiff(r_rect.left, i_px);
        r_a1  <= f_absdiff(r_rect.right, i_px);
        r_a2  <= f_absdiff(r_rect.bottom, i_py);
        r_a3  <= f_absdiff(r_rect.top, i_py);
        r_ax  <= f_absdiff(r_cx, i_px);
        r_ay  <= f_absdiff(r_cy, i_py);
        r_d4  <= {1'b0, r_ax} + {1'b0, r_ay};
        r_m01 <= (r_a1 < r_a0) ? r_a1 : r_a0;
        r_i01 <= (r_a1 < r_a0) ? C_CAND_RIGHT : C_CAND_LEFT;
        r_m23 <= (r_a3 < r_a2) ? r_a3 : r_a2;
        r_i23 <= (r_a3 < r_a2) ? C_CAND_TOP : C_CAND_BOTTOM;
        if (r_d4 < {1'b0, w_ma}) begin
            r_dmin <= r_d4;
            r_sel  <= C_CAND_CENTER;
        end else begin
            r_dmin <= {1'b0, w_ma};
            r_sel  <= w_ia;
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && (i_rem != '0) &&
            (r_dmin < {{(33 - C_BEST_BITS){1'b0}}, i_tok.best})) begin
            n_tok.best = r_dmin[C_BEST_BITS-1:0];
            n_tok.hit  = 1'b1;
            case (r_sel)
                C_CAND_LEFT: begin
                    n_tok.rx = r_rect.left;
                    n_tok.ry = i_py;
                end
                C_CAND_RIGHT: begin
                    n_tok.rx = r_rect.right;
                    n_tok.ry = i_py;
                end
                C_CAND_BOTTOM: begin
                    n_tok.rx = i_px;
                    n_tok.ry = r_rect.bottom;
                end
                C_CAND_TOP: begin
                    n_tok.rx = i_px;
                    n_tok.ry = r_rect.top;
                end
                default: begin
                    n_tok.rx = r_cx;
                    n_tok.ry = r_cy;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok.best <= n_tok.best;
        r_tok.rx   <= n_tok.rx;
        r_tok.ry   <= n_tok.ry;
        r_tok.hit  <= n_tok.hit;
        r_rem      <= (i_rem == '0) ? '0 : (i_rem - CW'(1));
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
    end

    assign o_tok = r_tok;
    assign o_rem = r_rem;

endmodule
